### sv/ice_pair_priority_ordered_table_core_macros.svh
// Assertion macros shared by the pair table RTL.
`ifndef ICE_PAIR_PRIORITY_ORDERED_TABLE_CORE_MACROS_SVH
`define ICE_PAIR_PRIORITY_ORDERED_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IPPOT_ASSERT_HOLD(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pair table assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define IPPOT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pair table assertion failed");

`endif

### sv/ippot_pkg.sv
// Types and constants for the candidate pair priority table.
package ippot_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_PRIO,
        ST_SCAN,
        ST_REPORT
    } state_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_ADDED    = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    // Configuration register indexes.
    localparam logic [0:0] REG_HOST_PREF = 1'b0;
    localparam logic [0:0] REG_ROLE      = 1'b1;

    // Address family codes; code 3 is folded onto the "other" code.
    localparam logic [1:0] FAM_IPV4  = 2'd0;
    localparam logic [1:0] FAM_IPV6  = 2'd1;
    localparam logic [1:0] FAM_OTHER = 2'd2;
    localparam logic [1:0] FAM_ALT   = 2'd3;

    // Family terms and the component ceiling of a host candidate priority.
    localparam logic [23:0] TERM_IPV4 = 24'd32767;
    localparam logic [23:0] TERM_IPV6 = 24'd65535;
    localparam logic [8:0]  COMP_TOP  = 9'd256;
    localparam logic [9:0]  COMP_MAX  = 10'd256;

endpackage

### sv/ice_pair_priority_ordered_table_core.sv
// An accepted start steps through PAIR, PRIO, SCAN and REPORT; SCAN walks the n pairs already stored.
// Rejected pairs (family mismatch or full table) skip SCAN and go from PRIO straight to REPORT.
// busy stays high until the done cycle ends; the next request is taken the cycle after.
// The rank comes from one shared 64-bit compare that walks the stored pairs, one a cycle.
// Reset (rst_n, asynchronous, active low) empties the table and loads the register defaults.
// The done strobe lasts one cycle and cannot be held off by the receiver.
module ice_pair_priority_ordered_table_core #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    // Request side.
    input  logic        start,
    output logic        busy,
    input  logic        local_present,
    input  logic [31:0] local_prio,
    input  logic [1:0]  local_family,
    input  logic [9:0]  local_component,
    input  logic        remote_present,
    input  logic [31:0] remote_prio,
    input  logic [1:0]  remote_family,
    input  logic [9:0]  remote_component,
    // Result side.
    output logic        done,
    output logic [1:0]  status,
    output logic [63:0] pair_priority,
    output logic [4:0]  rank,
    output logic [5:0]  pair_total
);
    import ippot_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Host candidate priority for a missing side, built from the other side.
    function automatic logic [31:0] host_prio(input logic [6:0] pref,
                                               input logic [1:0] fam,
                                               input logic [9:0] comp);
        logic [23:0] hi;
        logic [8:0]  c;
        logic [8:0]  low;
        hi = {1'b0, pref, 16'h0000};
        if (fam == FAM_IPV4)
        begin
            hi = hi + TERM_IPV4;
        end
        else if (fam == FAM_IPV6)
        begin
            hi = hi + TERM_IPV6;
        end
        if (comp == 10'd0)
        begin
            c = 9'd1;
        end
        else if (comp > COMP_MAX)
        begin
            c = COMP_TOP;
        end
        else
        begin
            c = comp[8:0];
        end
        low = COMP_TOP - c;
        return {hi, low[7:0]};
    endfunction

    function automatic logic [1:0] norm_family(input logic [1:0] fam);
        return (fam == FAM_ALT) ? FAM_OTHER : fam;
    endfunction

    // Configuration registers.
    logic [6:0] host_pref_reg;
    logic       role_reg;

    // Sequencer and table control.
    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  scan_idx_reg, scan_idx_next;
    logic [CW-1:0]  rank_reg, rank_next;
    logic           rd_valid_reg, rd_valid_next;

    // Captured request.
    logic        lp_reg, rp_reg;
    logic [31:0] lpri_reg, rpri_reg;
    logic [1:0]  lfam_reg, rfam_reg;
    logic [9:0]  lcomp_reg, rcomp_reg;

    // Datapath registers.
    logic [31:0] g_reg, g_next;
    logic [31:0] d_reg, d_next;
    logic        mismatch_reg, mismatch_next;
    logic        absent_reg, absent_next;
    logic [63:0] prio_reg, prio_next;
    status_t     status_reg, status_next;

    // Pair table in arrival order, with a registered read port.
    logic [63:0] table_mem [TABLE_DEPTH];
    logic [63:0] rd_data_reg;
    logic        mem_we;

    logic        accept;
    logic        table_full;
    logic [31:0] lv, rv;
    logic [31:0] mn, mx;

    assign accept     = start && (state_reg == ST_IDLE);
    assign table_full = (count_reg == CW'(TABLE_DEPTH));

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_pref_reg <= 7'd126;
            role_reg      <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HOST_PREF: host_pref_reg <= cfg_data;
                REG_ROLE:      role_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_PAIR;
                end
            end
            ST_PAIR:
            begin
                state_next = ST_PRIO;
            end
            ST_PRIO:
            begin
                if (mismatch_reg || table_full)
                begin
                    state_next = ST_REPORT;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_idx_reg == count_reg)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        busy   = (state_reg != ST_IDLE);
        done   = (state_reg == ST_REPORT);
        mem_we = (state_reg == ST_REPORT) && (status_reg == STATUS_ADDED);
    end

    // Candidate priorities and the smaller and larger of the two role values.
    always_comb
    begin
        lv = lp_reg ? lpri_reg : host_prio(host_pref_reg, rfam_reg, rcomp_reg);
        rv = rp_reg ? rpri_reg : host_prio(host_pref_reg, lfam_reg, lcomp_reg);
        mn = (g_reg < d_reg) ? g_reg : d_reg;
        mx = (g_reg < d_reg) ? d_reg : g_reg;
    end

    // Datapath next values.
    always_comb
    begin
        g_next        = g_reg;
        d_next        = d_reg;
        mismatch_next = mismatch_reg;
        absent_next   = absent_reg;
        prio_next     = prio_reg;
        status_next   = status_reg;
        rank_next     = rank_reg;
        scan_idx_next = scan_idx_reg;
        rd_valid_next = 1'b0;
        count_next    = count_reg;
        unique case (state_reg)
            ST_PAIR:
            begin
                g_next        = role_reg ? lv : rv;
                d_next        = role_reg ? rv : lv;
                mismatch_next = lp_reg && rp_reg && (lfam_reg != rfam_reg);
                absent_next   = !lp_reg && !rp_reg;
            end
            ST_PRIO:
            begin
                // One wide add forms the 64-bit pair priority.
                if (mismatch_reg || absent_reg)
                begin
                    prio_next = 64'd0;
                end
                else
                begin
                    prio_next = {mn, 32'h0000_0000} + {31'd0, mx, 1'b0}
                              + {63'd0, (g_reg > d_reg)};
                end
                priority if (mismatch_reg)
                begin
                    status_next = STATUS_MISMATCH;
                    prio_next   = 64'd0;
                end
                else if (table_full)
                begin
                    status_next = STATUS_FULL;
                end
                else
                begin
                    status_next = STATUS_ADDED;
                end
                rank_next     = '0;
                scan_idx_next = '0;
            end
            ST_SCAN:
            begin
                // Issue one table read a cycle; count entries at or above the new pair.
                if (scan_idx_reg != count_reg)
                begin
                    rd_valid_next = 1'b1;
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
                if (rd_valid_reg && (rd_data_reg >= prio_reg))
                begin
                    rank_next = rank_reg + 1'b1;
                end
            end
            ST_REPORT:
            begin
                if (status_reg == STATUS_ADDED)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            scan_idx_reg <= '0;
            rank_reg     <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_idx_reg <= scan_idx_next;
            rank_reg     <= rank_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lp_reg    <= local_present;
            lpri_reg  <= local_prio;
            lfam_reg  <= norm_family(local_family);
            lcomp_reg <= local_component;
            rp_reg    <= remote_present;
            rpri_reg  <= remote_prio;
            rfam_reg  <= norm_family(remote_family);
            rcomp_reg <= remote_component;
        end
        g_reg        <= g_next;
        d_reg        <= d_next;
        mismatch_reg <= mismatch_next;
        absent_reg   <= absent_next;
        prio_reg     <= prio_next;
        status_reg   <= status_next;
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[count_reg[AW-1:0]] <= prio_reg;
        end
        rd_data_reg <= table_mem[scan_idx_reg[AW-1:0]];
    end

    // Result ports.
    assign status        = status_reg;
    assign pair_priority = prio_reg;
    assign rank          = 5'(rank_reg);
    assign pair_total    = 6'({1'b0, count_reg}
                              + {{CW{1'b0}}, (status_reg == STATUS_ADDED)});

    // Checks on the sequencer and the table count.
`include "ice_pair_priority_ordered_table_core_macros.svh"
    `IPPOT_ASSERT_NEXT(a_accept_enters_pair, start && !busy, state_reg == ST_PAIR)
    `IPPOT_ASSERT_HOLD(a_rank_within_count, done, rank_reg <= count_reg)
    `IPPOT_ASSERT_NEXT(a_count_steps, mem_we, count_reg == $past(count_reg) + 1'b1)
    `IPPOT_ASSERT_HOLD(a_count_bounded, 1'b1, count_reg <= CW'(TABLE_DEPTH))

endmodule

### test/ice_pair_priority_ordered_table_core_tb.sv
// Self-checking testbench for the candidate pair priority table core.
`timescale 1ns / 1ps

module ice_pair_priority_ordered_table_core_tb;
    import ippot_pkg::*;

    // Table size of the block.
    localparam int DEPTH = 32;

    // One candidate pair request as it appears on the request ports.
    typedef struct {
        logic        local_present;
        logic [31:0] local_prio;
        logic [1:0]  local_family;
        logic [9:0]  local_component;
        logic        remote_present;
        logic [31:0] remote_prio;
        logic [1:0]  remote_family;
        logic [9:0]  remote_component;
    } pair_req_t;

    // One expected insertion report.
    typedef struct {
        status_t     status;
        logic [63:0] prio;
        logic [4:0]  rank;
        logic [5:0]  total;
    } table_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [6:0]  cfg_data = 7'd0;
    logic        start = 1'b0;
    logic        busy;
    logic        local_present = 1'b0;
    logic [31:0] local_prio = 32'd0;
    logic [1:0]  local_family = 2'd0;
    logic [9:0]  local_component = 10'd0;
    logic        remote_present = 1'b0;
    logic [31:0] remote_prio = 32'd0;
    logic [1:0]  remote_family = 2'd0;
    logic [9:0]  remote_component = 10'd0;
    logic        done;
    logic [1:0]  status;
    logic [63:0] pair_priority;
    logic [4:0]  rank;
    logic [5:0]  pair_total;

    // Requests waiting to be offered and reports waiting for their done strobe.
    pair_req_t     req_q[$];
    table_report_t due_reports[$];
    pair_req_t     held_req;

    // Shadow copy of the configuration and of the stored pair priorities.
    logic [6:0]  pref_cfg = 7'd126;
    logic        role_cfg = 1'b0;
    logic [63:0] table_prios[$];

    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;

    ice_pair_priority_ordered_table_core #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .start            (start),
        .busy             (busy),
        .local_present    (local_present),
        .local_prio       (local_prio),
        .local_family     (local_family),
        .local_component  (local_component),
        .remote_present   (remote_present),
        .remote_prio      (remote_prio),
        .remote_family    (remote_family),
        .remote_component (remote_component),
        .done             (done),
        .status           (status),
        .pair_priority    (pair_priority),
        .rank             (rank),
        .pair_total       (pair_total)
    );

    always #2 clk = ~clk;

    // Priority of a host candidate with index 0 for the given family and component.
    function automatic logic [31:0] host_cand_priority(logic [1:0] fam, logic [9:0] comp);
        logic [31:0] p;
        logic [9:0]  c;
        p = {9'd0, pref_cfg, 16'd0};
        if (fam == FAM_IPV4)
            p = p + {8'd0, TERM_IPV4};
        else if (fam == FAM_IPV6)
            p = p + {8'd0, TERM_IPV6};
        c = comp;
        if (c < 10'd1)
            c = 10'd1;
        if (c > COMP_MAX)
            c = COMP_MAX;
        return (p << 8) + ({23'd0, COMP_TOP} - {22'd0, c});
    endfunction

    // Computes the pair priority and inserts it into the shadow table.
    function automatic table_report_t place_pair(pair_req_t q);
        table_report_t rep;
        logic [1:0]    lf;
        logic [1:0]    rf;
        logic [31:0]   lv;
        logic [31:0]   rv;
        logic [31:0]   gp;
        logic [31:0]   dp;
        logic [31:0]   mn;
        logic [31:0]   mx;
        lf = (q.local_family == FAM_ALT) ? FAM_OTHER : q.local_family;
        rf = (q.remote_family == FAM_ALT) ? FAM_OTHER : q.remote_family;
        rep.status = STATUS_ADDED;
        rep.prio = 64'd0;
        rep.rank = 5'd0;
        if (q.local_present && q.remote_present && lf != rf) begin
            rep.status = STATUS_MISMATCH;
        end else begin
            if (q.local_present || q.remote_present) begin
                lv = q.local_present ? q.local_prio
                                     : host_cand_priority(rf, q.remote_component);
                rv = q.remote_present ? q.remote_prio
                                      : host_cand_priority(lf, q.local_component);
                gp = role_cfg ? lv : rv;
                dp = role_cfg ? rv : lv;
                mn = (gp < dp) ? gp : dp;
                mx = (gp > dp) ? gp : dp;
                rep.prio = {mn, 32'd0} + {31'd0, mx, 1'b0} + {63'd0, gp > dp};
            end
            if (table_prios.size() >= DEPTH) begin
                rep.status = STATUS_FULL;
            end else begin
                // A new pair goes after every stored pair of equal or higher priority.
                foreach (table_prios[i])
                    if (table_prios[i] >= rep.prio)
                        rep.rank = rep.rank + 5'd1;
                table_prios.insert(table_prios.size(), rep.prio);
            end
        end
        rep.total = 6'(table_prios.size());
        return rep;
    endfunction

    function automatic pair_req_t mk_pair(logic lp, logic [31:0] lpri, logic [1:0] lfam,
                                          logic [9:0] lcomp, logic rp, logic [31:0] rpri,
                                          logic [1:0] rfam, logic [9:0] rcomp);
        pair_req_t q;
        q.local_present = lp;
        q.local_prio = lpri;
        q.local_family = lfam;
        q.local_component = lcomp;
        q.remote_present = rp;
        q.remote_prio = rpri;
        q.remote_family = rfam;
        q.remote_component = rcomp;
        return q;
    endfunction

    // Appends one request to the pending queue.
    task automatic queue_req(pair_req_t q);
        req_q.insert(req_q.size(), q);
    endtask

    // Candidate priorities lean toward extremes and a small pool so that ties occur.
    function automatic logic [31:0] rand_prio();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7E00_0001;
            3: return 32'h6E7F_FFFF;
            4: return {30'd0, 2'($urandom_range(0, 3))};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 10'd0;
            1: return 10'd1;
            2: return 10'd256;
            3: return 10'd257;
            4: return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    // Mostly well-formed pairs of one family, plus one-sided, empty and noise pairs.
    function automatic pair_req_t rand_pair();
        pair_req_t q;
        int        kind;
        kind = $urandom_range(0, 99);
        q = mk_pair(1'($urandom_range(0, 1)), rand_prio(), 2'($urandom_range(0, 3)),
                    rand_comp(), 1'($urandom_range(0, 1)), rand_prio(),
                    2'($urandom_range(0, 3)), rand_comp());
        if (kind < 60) begin
            q.local_present = 1'b1;
            q.remote_present = 1'b1;
            if (q.local_family >= FAM_OTHER)
                q.remote_family = $urandom_range(0, 1) ? FAM_OTHER : FAM_ALT;
            else
                q.remote_family = q.local_family;
        end else if (kind < 80) begin
            q.remote_present = ~q.local_present;
        end else if (kind < 88) begin
            q.local_present = 1'b0;
            q.remote_present = 1'b0;
        end
        return q;
    endfunction

    task automatic write_reg(logic idx, logic [6:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_HOST_PREF)
            pref_cfg = val;
        else
            role_cfg = val[0];
    endtask

    // Waits until every queued request has been taken and every report has arrived.
    task automatic settle_table();
        while (req_q.size() != 0 || start || due_reports.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Request driver: offers queued pairs in bursts and predicts each accepted one.
    always @(posedge clk) begin : request_driver
        logic offer;
        offer = start;
        if (rst_n) begin
            if (start && !busy) begin
                due_reports.insert(due_reports.size(), place_pair(held_req));
                offer = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!offer) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (req_q.size() != 0) begin
                    held_req = req_q.pop_front();
                    local_present <= held_req.local_present;
                    local_prio <= held_req.local_prio;
                    local_family <= held_req.local_family;
                    local_component <= held_req.local_component;
                    remote_present <= held_req.remote_present;
                    remote_prio <= held_req.remote_prio;
                    remote_family <= held_req.remote_family;
                    remote_component <= held_req.remote_component;
                    offer = 1'b1;
                end
            end
        end
        start <= offer;
    end

    // Result monitor: compares each done strobe with the oldest pending report.
    always @(posedge clk) begin : result_monitor
        table_report_t want;
        if (rst_n && done) begin
            if (due_reports.size() == 0) begin
                if (errors < 40)
                    $display("%0t: unexpected result: status %0d priority %h rank %0d total %0d",
                             $time, status, pair_priority, rank, pair_total);
                errors++;
            end else begin
                want = due_reports.pop_front();
                if (status !== want.status || pair_priority !== want.prio ||
                    rank !== want.rank || pair_total !== want.total) begin
                    if (errors < 40) begin
                        $display("%0t: expected status %0d priority %h rank %0d total %0d",
                                 $time, want.status, want.prio, want.rank, want.total);
                        $display("%0t: actual   status %0d priority %h rank %0d total %0d",
                                 $time, status, pair_priority, rank, pair_total);
                    end
                    errors++;
                end
            end
        end
    end

    // Stimulus: directed pairs at reset settings, then random phases over several settings.
    initial begin
        logic [6:0] pv;
        logic       rv;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Empty pairs tie at zero; extreme priorities in every family.
        queue_req(mk_pair(1'b0, 32'd0, FAM_IPV4, 10'd0, 1'b0, 32'd0, FAM_IPV4, 10'd0));
        queue_req(mk_pair(1'b0, 32'd0, FAM_IPV4, 10'd0, 1'b0, 32'd0, FAM_IPV4, 10'd0));
        queue_req(mk_pair(1'b1, 32'hFFFF_FFFF, FAM_IPV4, 10'd1,
                          1'b1, 32'hFFFF_FFFF, FAM_IPV4, 10'd1));
        queue_req(mk_pair(1'b1, 32'd0, FAM_IPV6, 10'd2,
                          1'b1, 32'hFFFF_FFFF, FAM_IPV6, 10'd2));
        queue_req(mk_pair(1'b1, 32'hFFFF_FFFF, FAM_OTHER, 10'd3,
                          1'b1, 32'd0, FAM_OTHER, 10'd3));
        // One-sided pairs across families, with components at and beyond the clamp bounds.
        queue_req(mk_pair(1'b1, 32'h1234_5678, FAM_IPV4, 10'd0,
                          1'b0, 32'd0, FAM_IPV4, 10'd0));
        queue_req(mk_pair(1'b1, 32'h8000_0000, FAM_IPV6, 10'd1,
                          1'b0, 32'd0, FAM_IPV4, 10'd0));
        queue_req(mk_pair(1'b1, 32'h0000_FFFF, FAM_OTHER, 10'd256,
                          1'b0, 32'd0, FAM_IPV4, 10'd0));
        queue_req(mk_pair(1'b0, 32'd0, FAM_IPV4, 10'd0,
                          1'b1, 32'h7E00_0001, FAM_ALT, 10'd257));
        queue_req(mk_pair(1'b0, 32'd0, FAM_IPV6, 10'd5,
                          1'b1, 32'h0000_0001, FAM_IPV4, 10'd1023));
        // Family mismatches, the folded family code, and further matched, one-sided and empty pairs.
        queue_req(mk_pair(1'b1, 32'd7, FAM_IPV4, 10'd1, 1'b1, 32'd7, FAM_IPV6, 10'd1));
        queue_req(mk_pair(1'b1, 32'd7, FAM_IPV6, 10'd1, 1'b1, 32'd7, FAM_ALT, 10'd1));
        queue_req(mk_pair(1'b1, 32'hAAAA_5555, FAM_OTHER, 10'd9,
                          1'b1, 32'h5555_AAAA, FAM_ALT, 10'd9));
        queue_req(mk_pair(1'b1, 32'hFFFF_FFFF, FAM_IPV4, 10'd1,
                          1'b1, 32'hFFFF_FFFF, FAM_IPV4, 10'd1));
        queue_req(mk_pair(1'b0, 32'hFFFF_FFFF, FAM_ALT, 10'd1023,
                          1'b1, 32'hDEAD_BEEF, FAM_IPV6, 10'd512));
        queue_req(mk_pair(1'b1, 32'd1, FAM_IPV4, 10'd1, 1'b1, 32'd2, FAM_IPV4, 10'd1));
        queue_req(mk_pair(1'b1, 32'd2, FAM_IPV4, 10'd1, 1'b1, 32'd1, FAM_IPV4, 10'd1));
        queue_req(mk_pair(1'b1, 32'd3, FAM_IPV4, 10'd1, 1'b1, 32'd3, FAM_OTHER, 10'd1));
        queue_req(mk_pair(1'b0, 32'hFFFF_FFFF, FAM_ALT, 10'd1023,
                          1'b0, 32'hFFFF_FFFF, FAM_ALT, 10'd1023));
        settle_table();

        // Random phases; the first four settings cover the register extremes.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin pv = 7'd0;   rv = 1'b1; end
                1: begin pv = 7'd127; rv = 1'b0; end
                2: begin pv = 7'd126; rv = 1'b1; end
                3: begin pv = 7'd0;   rv = 1'b0; end
                default:
                begin
                    pv = 7'($urandom_range(0, 127));
                    rv = 1'($urandom_range(0, 1));
                end
            endcase
            write_reg(REG_HOST_PREF, pv);
            write_reg(REG_ROLE, {6'd0, rv});
            repeat (160) queue_req(rand_pair());
            settle_table();
        end

        repeat (40) @(posedge clk);
        if (errors == 0 && due_reports.size() == 0)
            $display("ice_pair_priority_ordered_table_core_tb: clean");
        else
            $display("ice_pair_priority_ordered_table_core_tb: errors");
        $finish;
    end

    // Run limit, several times the slowest correct run.
    initial begin
        #2000000;
        $display("ice_pair_priority_ordered_table_core_tb: errors");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/ippot_pkg.sv
sv/ice_pair_priority_ordered_table_core.sv
test/ice_pair_priority_ordered_table_core_tb.sv
